>>> rtl/core/chained_name_hash_table_top_defines.svh
// ============================================================================
// Assertion macros for the chained name hash table
// Shared property forms, clocked on i_clk and held off during reset.
// ============================================================================
`ifndef CHAINED_NAME_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_NAME_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define CNHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CNHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/cnht_pkg.sv
// ============================================================================
// cnht_pkg
// Types, codes and helper functions of the chained name hash table.
// ============================================================================
package cnht_pkg;

    localparam int CNHT_MAX_ENTRIES = 1024;
    localparam int CNHT_BUCKETS     = 1024;

    localparam int NAME_W  = 64;
    localparam int SPACE_W = 3;
    localparam int OUT_W   = 10;
    // The hash of a normalized name never exceeds 17 bits; kept with some margin.
    localparam int HASH_W  = 20;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_WALK,
        S_ENT_WAIT,
        S_RESP
    } t_state;

    // Upper-case a-z and clear every byte after the first zero byte.
    function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] o;
        logic              stop;
        logic [7:0]        b;
        o    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            b = raw[8*i +: 8];
            if (b == 8'h00) begin
                stop = 1'b1;
            end
            if (b >= 8'h61 && b <= 8'h7a) begin
                b = b - 8'h20;
            end
            if (!stop) begin
                o[8*i +: 8] = b;
            end
        end
        return o;
    endfunction

    // Hash of a normalized name, before reduction to a bucket.
    function automatic logic [HASH_W-1:0] name_hash(input logic [NAME_W-1:0] n);
        logic [HASH_W-1:0] h;
        logic              stop;
        h = HASH_W'(n[7:0]);
        stop = 1'b0;
        if (n[15:8] != 8'h00) begin
            h = HASH_W'(h * 3) + HASH_W'(n[15:8]);
            for (int k = 2; k < 6; k++) begin
                if (n[8*k +: 8] == 8'h00) begin
                    stop = 1'b1;
                end
                if (!stop) begin
                    h = {h[HASH_W-2:0], 1'b0} + HASH_W'(n[8*k +: 8]);
                end
            end
            if (!stop && n[55:48] != 8'h00) begin
                h = {h[HASH_W-2:0], 1'b0} + HASH_W'(n[55:48]);
                h = {h[HASH_W-2:0], 1'b0} + HASH_W'(n[63:56]);
            end
        end
        return h;
    endfunction

endpackage

>>> rtl/core/cnht_ram.sv
// ============================================================================
// cnht_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ============================================================================
module cnht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/chained_name_hash_table_top.sv
// ============================================================================
// chained_name_hash_table_top
// Directory of 8-byte names with namespace tags in a chained hash table.
// ============================================================================
// A command item is taken when start is high and busy is low; its one result
// appears on o_status and o_entry_index for a single cycle with o_valid high,
// and the receiver cannot stall it. Names are upper-cased and cut at their
// first zero byte, hashed, and reduced modulo the bucket count by a reciprocal
// multiplication that forms the quotient and then the remainder. An insert
// reads its bucket head, writes the new entry and head, and then answers; an
// insert into a full table answers "full" straight after the hash state. A
// lookup visits its chain one entry at a time, each visit being one registered
// read of the entry memory, and answers on a match or when it runs off the
// end of its chain. A clear sweeps the bucket-head memory one entry per cycle
// and answers at the end of the sweep; the same sweep runs after reset, with
// no result, and busy stays high until it ends. Unused command code 3 goes
// straight to the response state and answers "not found".
// ============================================================================
`include "chained_name_hash_table_top_defines.svh"

module chained_name_hash_table_top
    import cnht_pkg::*;
#(
    parameter int MAX_ENTRIES = CNHT_MAX_ENTRIES,
    parameter int BUCKETS     = CNHT_BUCKETS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [NAME_W-1:0]  i_key_name,
    input  logic [SPACE_W-1:0] i_name_space,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [OUT_W-1:0]   o_entry_index
);

    // Entry index width, link width (index + 1, zero meaning end of chain),
    // bucket address width and remainder width of the modulo unit.
    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int LW  = $clog2(MAX_ENTRIES + 1);
    localparam int BAW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW  = $clog2(BUCKETS) + 1;
    localparam int EW  = NAME_W + SPACE_W + LW;

    // The quotient h / BUCKETS is floor(h * RECIP / 2^SH) for every hash value
    // below 2^HASH_W when RECIP is 2^SH / BUCKETS rounded up.
    localparam int SH = HASH_W + $clog2(BUCKETS);
    localparam int MW = HASH_W + 1;
    localparam int PW = HASH_W + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [NAME_W-1:0]   r_name;
    logic [SPACE_W-1:0]  r_space;
    logic [HASH_W-1:0]   r_h;
    logic [HASH_W-1:0]   r_q;
    logic [RW-1:0]       r_rem;
    logic                r_dig;
    logic [LW-1:0]       r_p;
    logic [IW:0]         r_cnt;
    logic [BAW-1:0]      r_clr;
    logic                r_clr_ack;
    logic                r_valid;
    t_status             r_status;
    logic [OUT_W-1:0]    r_index;

    logic                head_we;
    logic [BAW-1:0]      head_waddr;
    logic [LW-1:0]       head_wdata;
    logic [LW-1:0]       head_rdata;
    logic                ent_we;
    logic [EW-1:0]       ent_wdata;
    logic [EW-1:0]       ent_rdata;
    logic [IW-1:0]       ent_raddr;

    logic                accept;
    logic                full;
    logic                clr_last;
    logic [PW-1:0]       quot_prod;
    logic [HASH_W-1:0]   q_times_b;
    logic [HASH_W-1:0]   rem_full;
    logic [NAME_W-1:0]   ent_name;
    logic [SPACE_W-1:0]  ent_space;
    logic [LW-1:0]       ent_link;
    logic                ent_match;
    logic [IW-1:0]       cur_idx;
    logic [IW+OUT_W-1:0] idx_wide;
    logic [IW+OUT_W-1:0] cnt_wide;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_cnt >= (IW + 1)'(MAX_ENTRIES));
    assign clr_last = (r_clr == BAW'(BUCKETS - 1));

    // Modulo unit: S_MOD forms the quotient while r_dig is low, then the remainder.
    // The product q * BUCKETS never exceeds the hash, so it fits in HASH_W bits.
    assign quot_prod = r_h * RECIP;
    assign q_times_b = HASH_W'(r_q * HASH_W'(BUCKETS));
    assign rem_full  = r_h - q_times_b;

    assign {ent_name, ent_space, ent_link} = ent_rdata;
    assign ent_match = (ent_name == r_name) && (ent_space == r_space);
    assign cur_idx   = IW'(r_p - 1'b1);
    assign idx_wide  = (IW + OUT_W)'(cur_idx);
    assign cnt_wide  = (IW + OUT_W)'(r_cnt[IW-1:0]);

    // Bucket heads: cleared by the sweep, written by inserts.
    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_rem[BAW-1:0];
        head_wdata = LW'(r_cnt + 1'b1);
        if (r_state == S_CLEAR) begin
            head_we    = 1'b1;
            head_waddr = r_clr;
            head_wdata = '0;
        end else if (r_state == S_HEAD_WAIT && r_cmd == CMD_INSERT) begin
            head_we = 1'b1;
        end
    end

    assign ent_we    = (r_state == S_HEAD_WAIT) && (r_cmd == CMD_INSERT);
    assign ent_wdata = {r_name, r_space, head_rdata};
    assign ent_raddr = cur_idx;

    cnht_ram #(
        .WIDTH (LW),
        .DEPTH (BUCKETS),
        .AW    (BAW)
    ) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (r_rem[BAW-1:0]),
        .o_rdata (head_rdata)
    );

    cnht_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_INSERT: n_state = S_HASH;
                        CMD_LOOKUP: n_state = S_HASH;
                        CMD_CLEAR:  n_state = S_CLEAR;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_HASH: begin
                if (r_cmd == CMD_INSERT && full) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_dig) begin
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD:   n_state = S_HEAD_WAIT;
            S_HEAD_WAIT: n_state = (r_cmd == CMD_INSERT) ? S_RESP : S_WALK;
            S_WALK:      n_state = (r_p == '0) ? S_RESP : S_ENT_WAIT;
            S_ENT_WAIT:  n_state = ent_match ? S_RESP : S_WALK;
            S_RESP:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_clr_ack <= 1'b0;
            r_cnt     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_RESP) || (r_state == S_CLEAR && clr_last && r_clr_ack);
            if (r_state == S_CLEAR) begin
                r_clr <= clr_last ? '0 : r_clr + 1'b1;
                if (clr_last) begin
                    r_clr_ack <= 1'b0;
                end
            end
            if (accept && t_cmd'(i_cmd) == CMD_CLEAR) begin
                r_clr_ack <= 1'b1;
                r_cnt     <= '0;
            end
            if (ent_we) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_name  <= normalize(i_key_name);
            r_space <= i_name_space;
        end
        case (r_state)
            S_IDLE: begin
                r_status <= ST_NOTFOUND;
                r_index  <= '0;
            end
            S_HASH: begin
                r_h   <= name_hash(r_name);
                r_rem <= '0;
                r_dig <= 1'b0;
                if (r_cmd == CMD_INSERT && full) begin
                    r_status <= ST_FULL;
                end
            end
            S_MOD: begin
                if (!r_dig) begin
                    r_q <= HASH_W'(quot_prod >> SH);
                end else begin
                    r_rem <= rem_full[RW-1:0];
                end
                r_dig <= 1'b1;
            end
            S_HEAD_WAIT: begin
                r_p <= head_rdata;
                if (r_cmd == CMD_INSERT) begin
                    r_status <= ST_OK;
                    r_index  <= cnt_wide[OUT_W-1:0];
                end
            end
            S_ENT_WAIT: begin
                if (ent_match) begin
                    r_status <= ST_OK;
                    r_index  <= idx_wide[OUT_W-1:0];
                end else begin
                    r_p <= ent_link;
                end
            end
            S_CLEAR: begin
                r_status <= ST_OK;
                r_index  <= '0;
            end
            default: begin
                r_index <= r_index;
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_entry_index = r_index;

    `CNHT_ASSERT_NEXT(a_start_busy, accept, busy, "accepted item did not raise busy")
    `CNHT_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= (IW + 1)'(MAX_ENTRIES), "entry count overrun")
    `CNHT_ASSERT_NOW(a_idx_zero, o_valid && o_status != ST_OK, o_entry_index == '0, "index set on failure")
    `CNHT_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result shown while still busy")

endmodule
